[sv/perlin_noise_2d_top_assert.svh]
// assertion macros for the perlin noise block
`ifndef PERLIN_NOISE_2D_TOP_ASSERT_SVH
`define PERLIN_NOISE_2D_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PN2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PN2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pn2d_pkg.sv]
package pn2d_pkg;

  // coordinate and table geometry
  localparam int CRD_W     = 32;
  localparam int IDX_W     = 8;
  localparam int BANK_AW   = IDX_W - 1;
  localparam int TBL_DEPTH = 1 << IDX_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int OUT_FRAC  = 16;
  localparam int OUT_W     = 19;

  // internal widths
  localparam int SW = FRAC_BITS + 5;   // fade inner term, signed
  localparam int CW = FRAC_BITS + 4;   // fade polynomial tail, positive
  localparam int UW = FRAC_BITS + 1;   // eased weight, 0 to one
  localparam int GW = FRAC_BITS + 3;   // corner gradient and blend, signed
  localparam int DW = FRAC_BITS + 4;   // blend difference, signed
  localparam int PW = UW + 1 + DW;     // blend product

  localparam int SHR = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int SHL = (FRAC_BITS <  OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;

  localparam logic signed [GW-1:0] ONE_G = GW'(1) <<< FRAC_BITS;

  // word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // gradient codes from the low two hash bits
  localparam logic [1:0] GRAD_PP = 2'd0;   // dx + dy
  localparam logic [1:0] GRAD_NP = 2'd1;   // -dx + dy
  localparam logic [1:0] GRAD_PN = 2'd2;   // dx - dy
  localparam logic [1:0] GRAD_NN = 2'd3;   // -dx - dy

  function automatic logic signed [GW-1:0] corner_dot(
    input logic [1:0]           h,
    input logic signed [GW-1:0] dx,
    input logic signed [GW-1:0] dy
  );
    logic signed [GW-1:0] g;
    case (h)
      GRAD_PP: g = dx + dy;
      GRAD_NP: g = dy - dx;
      GRAD_PN: g = dx - dy;
      GRAD_NN: g = -dx - dy;
      default: g = dx + dy;
    endcase
    return g;
  endfunction

endpackage

[sv/perlin_noise_2d_top.sv]
// 2-d gradient noise, eight-stage pipeline ending in the output register
// throughput one word per clock while in_stall is low, loads and evaluations freely mixed; loads give no result
// the rate is set by the permutation memories, read twice per word (cell, then corner hash)
// stages hold individually under output stall, so bubbles are squeezed out before stalling input
// synchronous active-high reset clears only the stage valid flags; table contents are
// undefined until loaded
`include "perlin_noise_2d_top_assert.svh"

module perlin_noise_2d_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [pn2d_pkg::IDX_W-1:0]           table_index,
  input  logic [pn2d_pkg::IDX_W-1:0]           table_value,
  input  logic signed [pn2d_pkg::CRD_W-1:0]    x_coord,
  input  logic signed [pn2d_pkg::CRD_W-1:0]    y_coord,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pn2d_pkg::OUT_W-1:0]    noise_value
);
  import pn2d_pkg::*;

  // ---------------------------------------------------------------------------
  // pipeline control: en[k] means stage k may capture this cycle
  // ---------------------------------------------------------------------------
  logic [7:1] vld;
  logic [8:1] en;
  logic       accept;
  logic       accept_load;

  always_comb begin
    en[8] = !out_valid || !out_stall;
    en[7] = !vld[7] || en[8];
    en[6] = !vld[6] || en[7];
    en[5] = !vld[5] || en[6];
    en[4] = !vld[4] || en[5];
    en[3] = !vld[3] || en[4];
    en[2] = !vld[2] || en[3];
    en[1] = !vld[1] || en[2];
  end

  // input is held off only when stage 1 itself is blocked; this also keeps
  // every later load behind the corner-hash read of an earlier evaluation
  assign in_stall    = !en[1];
  assign accept      = in_valid && en[1];
  assign accept_load = accept && (kind == KIND_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en[1]) vld[1] <= in_valid && (kind == KIND_EVAL);
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
      if (en[5]) vld[5] <= vld[4];
      if (en[6]) vld[6] <= vld[5];
      if (en[7]) vld[7] <= vld[6];
      if (en[8]) out_valid <= vld[7];
    end
  end

  // ---------------------------------------------------------------------------
  // permutation table, held in two memories
  //   cell_mem: full copy, read at cell and cell+1 as the word enters
  //   even/odd banks: interleaved copy, read at the two hash pairs one stage
  //   later; each pair is one even and one odd entry, so two reads per bank
  // a load writes both at acceptance; reads in the same edge see old data,
  // which is right since the load follows any evaluation already in flight
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] cell_mem [TBL_DEPTH];
  logic [IDX_W-1:0] even_mem [BANK_DEPTH];
  logic [IDX_W-1:0] odd_mem  [BANK_DEPTH];

  logic [IDX_W-1:0] cx_in;
  logic [IDX_W-1:0] cx_in_p1;

  assign cx_in    = x_coord[FRAC_BITS +: IDX_W];
  assign cx_in_p1 = cx_in + IDX_W'(1);

  // stage 1 registers
  logic [FRAC_BITS-1:0] fx_s1, fy_s1;
  logic [IDX_W-1:0]     cy_s1;
  logic [IDX_W-1:0]     pa0_s1, pa1_s1;

  always_ff @(posedge clk) begin
    if (accept_load) cell_mem[table_index] <= table_value;
    if (en[1]) begin
      pa0_s1 <= cell_mem[cx_in];
      pa1_s1 <= cell_mem[cx_in_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fx_s1 <= x_coord[FRAC_BITS-1:0];
      fy_s1 <= y_coord[FRAC_BITS-1:0];
      cy_s1 <= y_coord[FRAC_BITS +: IDX_W];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 -> 2: corner hash read, first fade products
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]   hx0, hx1, hx0_p1, hx1_p1;
  logic [BANK_AW-1:0] ev_addr0, od_addr0, ev_addr1, od_addr1;

  always_comb begin
    hx0    = pa0_s1 + cy_s1;
    hx1    = pa1_s1 + cy_s1;
    hx0_p1 = hx0 + IDX_W'(1);
    hx1_p1 = hx1 + IDX_W'(1);
    // odd base: the odd entry is the base, the even one comes after it
    ev_addr0 = hx0[0] ? hx0_p1[IDX_W-1:1] : hx0[IDX_W-1:1];
    od_addr0 = hx0[0] ? hx0[IDX_W-1:1]    : hx0_p1[IDX_W-1:1];
    ev_addr1 = hx1[0] ? hx1_p1[IDX_W-1:1] : hx1[IDX_W-1:1];
    od_addr1 = hx1[0] ? hx1[IDX_W-1:1]    : hx1_p1[IDX_W-1:1];
  end

  logic [IDX_W-1:0] be0_s2, bo0_s2, be1_s2, bo1_s2;
  logic             sw0_s2, sw1_s2;

  always_ff @(posedge clk) begin
    if (accept_load && !table_index[0]) even_mem[table_index[IDX_W-1:1]] <= table_value;
    if (en[2]) begin
      be0_s2 <= even_mem[ev_addr0];
      be1_s2 <= even_mem[ev_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept_load && table_index[0]) odd_mem[table_index[IDX_W-1:1]] <= table_value;
    if (en[2]) begin
      bo0_s2 <= odd_mem[od_addr0];
      bo1_s2 <= odd_mem[od_addr1];
    end
  end

  // fade: s = t*(6t - 15), t2 = t*t
  logic signed [SW-1:0]          mx, my;
  logic signed [FRAC_BITS+SW:0]  psx, psy;
  logic [2*FRAC_BITS-1:0]        qx, qy;

  always_comb begin
    mx  = $signed(SW'(fx_s1) * SW'(6) - (SW'(15) << FRAC_BITS));
    my  = $signed(SW'(fy_s1) * SW'(6) - (SW'(15) << FRAC_BITS));
    psx = (FRAC_BITS+SW+1)'($signed({1'b0, fx_s1})) * (FRAC_BITS+SW+1)'(mx);
    psy = (FRAC_BITS+SW+1)'($signed({1'b0, fy_s1})) * (FRAC_BITS+SW+1)'(my);
    qx  = (2*FRAC_BITS)'(fx_s1) * (2*FRAC_BITS)'(fx_s1);
    qy  = (2*FRAC_BITS)'(fy_s1) * (2*FRAC_BITS)'(fy_s1);
  end

  logic [FRAC_BITS-1:0]  fx_s2, fy_s2, t2x_s2, t2y_s2;
  logic signed [SW-1:0]  sx_s2, sy_s2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fx_s2  <= fx_s1;
      fy_s2  <= fy_s1;
      sx_s2  <= psx[FRAC_BITS +: SW];
      sy_s2  <= psy[FRAC_BITS +: SW];
      t2x_s2 <= qx[FRAC_BITS +: FRAC_BITS];
      t2y_s2 <= qy[FRAC_BITS +: FRAC_BITS];
      sw0_s2 <= hx0[0];
      sw1_s2 <= hx1[0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2 -> 3: cube term, polynomial tail, corner gradients
  // ---------------------------------------------------------------------------
  logic [2*FRAC_BITS-1:0] q3x, q3y;
  logic signed [SW-1:0]   csx, csy;
  logic [IDX_W-1:0]       h00, h01, h10, h11;
  logic signed [GW-1:0]   dx0, dy0, dx1, dy1;

  always_comb begin
    q3x = (2*FRAC_BITS)'(t2x_s2) * (2*FRAC_BITS)'(fx_s2);
    q3y = (2*FRAC_BITS)'(t2y_s2) * (2*FRAC_BITS)'(fy_s2);
    csx = sx_s2 + $signed(SW'(10) << FRAC_BITS);
    csy = sy_s2 + $signed(SW'(10) << FRAC_BITS);
    h00 = sw0_s2 ? bo0_s2 : be0_s2;
    h01 = sw0_s2 ? be0_s2 : bo0_s2;
    h10 = sw1_s2 ? bo1_s2 : be1_s2;
    h11 = sw1_s2 ? be1_s2 : bo1_s2;
    dx0 = $signed(GW'(fx_s2));
    dy0 = $signed(GW'(fy_s2));
    dx1 = dx0 - ONE_G;
    dy1 = dy0 - ONE_G;
  end

  logic [FRAC_BITS-1:0] t3x_s3, t3y_s3;
  logic [CW-1:0]        cx_s3, cy_s3;
  logic signed [GW-1:0] g00_s3, g10_s3, g01_s3, g11_s3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3x_s3 <= q3x[FRAC_BITS +: FRAC_BITS];
      t3y_s3 <= q3y[FRAC_BITS +: FRAC_BITS];
      cx_s3  <= csx[CW-1:0];
      cy_s3  <= csy[CW-1:0];
      g00_s3 <= corner_dot(h00[1:0], dx0, dy0);
      g10_s3 <= corner_dot(h10[1:0], dx1, dy0);
      g01_s3 <= corner_dot(h01[1:0], dx0, dy1);
      g11_s3 <= corner_dot(h11[1:0], dx1, dy1);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3 -> 4: eased weights
  // ---------------------------------------------------------------------------
  logic [FRAC_BITS+CW-1:0] pux, puy;

  always_comb begin
    pux = (FRAC_BITS+CW)'(t3x_s3) * (FRAC_BITS+CW)'(cx_s3);
    puy = (FRAC_BITS+CW)'(t3y_s3) * (FRAC_BITS+CW)'(cy_s3);
  end

  logic [UW-1:0]        u_s4, v_s4;
  logic signed [GW-1:0] g00_s4, g10_s4, g01_s4, g11_s4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      u_s4   <= pux[FRAC_BITS +: UW];
      v_s4   <= puy[FRAC_BITS +: UW];
      g00_s4 <= g00_s3;
      g10_s4 <= g10_s3;
      g01_s4 <= g01_s3;
      g11_s4 <= g11_s3;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4 -> 5: blend along x, products
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] dlo, dhi;
  logic signed [PW-1:0] plo, phi;

  always_comb begin
    dlo = DW'(g10_s4) - DW'(g00_s4);
    dhi = DW'(g11_s4) - DW'(g01_s4);
    plo = PW'($signed({1'b0, u_s4})) * PW'(dlo);
    phi = PW'($signed({1'b0, u_s4})) * PW'(dhi);
  end

  logic signed [PW-1:0] plo_s5, phi_s5;
  logic signed [GW-1:0] g00_s5, g01_s5;
  logic [UW-1:0]        v_s5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      plo_s5 <= plo;
      phi_s5 <= phi;
      g00_s5 <= g00_s4;
      g01_s5 <= g01_s4;
      v_s5   <= v_s4;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5 -> 6: blend along x, sums
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] alo, ahi;

  always_comb begin
    alo = DW'(g00_s5) + $signed(plo_s5[FRAC_BITS +: DW]);
    ahi = DW'(g01_s5) + $signed(phi_s5[FRAC_BITS +: DW]);
  end

  logic signed [GW-1:0] a0_s6, a1_s6;
  logic [UW-1:0]        v_s6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      a0_s6 <= alo[GW-1:0];
      a1_s6 <= ahi[GW-1:0];
      v_s6  <= v_s5;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6 -> 7: blend along y, product
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] dy_bl;
  logic signed [PW-1:0] py_bl;

  always_comb begin
    dy_bl = DW'(a1_s6) - DW'(a0_s6);
    py_bl = PW'($signed({1'b0, v_s6})) * PW'(dy_bl);
  end

  logic signed [PW-1:0] py_s7;
  logic signed [GW-1:0] a0_s7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      py_s7 <= py_bl;
      a0_s7 <= a0_s6;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7 -> output word: final sum and output scaling
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]    rsum;
  logic signed [GW-1:0]    r_bl;
  logic signed [OUT_W-1:0] noise_next;

  always_comb begin
    rsum       = DW'(a0_s7) + $signed(py_s7[FRAC_BITS +: DW]);
    r_bl       = rsum[GW-1:0];
    noise_next = OUT_W'(r_bl >>> SHR) <<< SHL;
  end

  // output register parts the pipeline from the consumer
  always_ff @(posedge clk) begin
    if (en[8]) noise_value <= noise_next;
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `PN2D_ASSERT_IMP(a_hold_blocks_input, vld[1] && !en[2], in_stall, "stage 1 blocked but input open")
  `PN2D_ASSERT_IMP(a_out_from_stage7, $rose(out_valid), $past(vld[7]), "output word without stage 7 source")
  `PN2D_ASSERT_IMP(a_noise_range, out_valid, (noise_value >= -19'sd131072) && (noise_value <= 19'sd131072), "noise out of range")

endmodule
